### rtl/ntm_pkg.sv
// Shared constants, command codes and entry type for the nearest tower match block.
package ntm_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ETA_W   = 13;
    localparam int PHI_W   = 12;
    localparam int EN_W    = 16;
    localparam int DSQ_W   = 27;
    localparam int ROOT_W  = 14;
    localparam int SQ_STEPS = (DSQ_W + 1) / 2;
    localparam int STEP_W  = $clog2(SQ_STEPS);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic        [EN_W-1:0]  energy;
    } t_entry;

endpackage

### rtl/ntm_store.sv
// Entry store with one write port and one registered read port.
module ntm_store
    import ntm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ntm_sqrt.sv
// Iterative floor square root, one result bit per cycle.
module ntm_sqrt
    import ntm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DSQ_W-1:0]  i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DSQ_W-1:0]  r_rem, n_rem;
    logic [DSQ_W:0]    r_res, n_res;
    logic [DSQ_W:0]    r_bit, n_bit;
    logic [DSQ_W:0]    trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = i_value;
            n_res  = '0;
            n_bit  = (DSQ_W + 1)'(1) << (2 * (SQ_STEPS - 1));
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                n_rem = r_rem - trial[DSQ_W-1:0];
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit  = r_bit >> 2;
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(SQ_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

### rtl/nearest_tower_match.sv
// Top level of the nearest tower match block: sequencer, distance pipeline and result register.
// Clear and append beats are handled as they are accepted. A query scans the stored entries one per cycle
// through the store's single read port and a four-stage distance pipeline, then runs the
// bit-serial square root of 14 steps. On an empty store the query goes straight to the result,
// with no scan and no square root. The input is not ready while a query is in progress. A
// finished result waits in the output register while the next beat is taken; a later query
// holds its result until that register is free.
module nearest_tower_match
    import ntm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: item_eta[12:0], item_phi[24:13], item_energy[40:25], zero fill.
    input  logic [47:0] s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: match_index[11:0], match_energy[27:12], distance_sq[54:28],
    // distance[68:55], zero fill.
    output logic [71:0] m_axis_tdata,
    // Fields from bit 0: found[0].
    output logic [0:0]  m_axis_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]              r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_addr;
    logic signed [ETA_W-1:0] r_q_eta;
    logic signed [PHI_W-1:0] r_q_phi;

    logic                    accept;
    logic [1:0]              in_cmd;
    t_entry                  in_entry;
    logic                    wr_en;
    logic                    rd_en;
    t_entry                  rd_data;

    logic                    r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]        r_idx1, r_idx2, r_idx3;
    logic [ETA_W-1:0]        r_ade;
    logic [PHI_W-1:0]        r_adp;
    logic [EN_W-1:0]         r_en2, r_en3;
    logic [2*ETA_W-1:0]      r_sqe;
    logic [2*PHI_W-2:0]      r_sqp;

    logic signed [ETA_W:0]   de;
    logic [ETA_W:0]          ade;
    logic [PHI_W-1:0]        dp;
    logic [PHI_W-1:0]        adp;
    logic [DSQ_W-1:0]        dsum;

    logic                    r_have;
    logic [DSQ_W-1:0]        r_best_d;
    logic [IDX_W-1:0]        r_best_idx;
    logic [EN_W-1:0]         r_best_en;
    logic [ROOT_W-1:0]       r_root;

    logic                    sq_start;
    logic                    sq_done;
    logic [ROOT_W-1:0]       sq_root;
    logic                    out_free;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [11:0]             r_out_idx;
    logic [EN_W-1:0]         r_out_en;
    logic [DSQ_W-1:0]        r_out_dsq;
    logic [ROOT_W-1:0]       r_out_root;

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign accept          = s_axis_tvalid && s_axis_tready;
    assign in_cmd          = s_axis_tuser;
    assign in_entry.eta    = s_axis_tdata[12:0];
    assign in_entry.phi    = s_axis_tdata[24:13];
    assign in_entry.energy = s_axis_tdata[40:25];

    assign wr_en    = accept && (in_cmd == CMD_APPEND) && (r_cnt < CNT_W'(MAX_ENTRIES));
    assign rd_en    = (r_state == ST_SCAN);
    assign sq_start = (r_state == ST_DRAIN) && !r_v1 && !r_v2 && !r_v3;
    assign out_free = !r_out_valid || m_axis_tready;

    ntm_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[IDX_W-1:0]),
        .i_wr_data (in_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    ntm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_best_d),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        de   = (ETA_W + 1)'(r_q_eta) - (ETA_W + 1)'(rd_data.eta);
        ade  = de[ETA_W] ? (ETA_W + 1)'(-de) : de;
        dp   = r_q_phi - rd_data.phi;
        adp  = (dp[PHI_W-1] && (dp[PHI_W-2:0] != '0)) ? PHI_W'(-dp) : dp;
        dsum = DSQ_W'(r_sqe) + DSQ_W'(r_sqp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (in_cmd == CMD_CLEAR) begin
                            r_cnt <= '0;
                        end else if (wr_en) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else if (in_cmd == CMD_QUERY) begin
                            r_state <= (r_cnt == '0) ? ST_DONE : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (CNT_W'(r_addr) == r_cnt - 1'b1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (sq_start) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (in_cmd == CMD_QUERY)) begin
            r_q_eta <= in_entry.eta;
            r_q_phi <= in_entry.phi;
            r_addr  <= '0;
            r_have  <= 1'b0;
        end else begin
            if (rd_en) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_v3 && (!r_have || (dsum < r_best_d))) begin
                r_have     <= 1'b1;
                r_best_d   <= dsum;
                r_best_idx <= r_idx3;
                r_best_en  <= r_en3;
            end
        end
        r_idx1 <= r_addr;
        r_idx2 <= r_idx1;
        r_ade  <= ade[ETA_W-1:0];
        r_adp  <= adp;
        r_en2  <= rd_data.energy;
        r_idx3 <= r_idx2;
        r_sqe  <= r_ade * r_ade;
        r_sqp  <= (2*PHI_W - 1)'(r_adp * r_adp);
        r_en3  <= r_en2;
        if (sq_done) begin
            r_root <= sq_root;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_found <= r_have;
            r_out_idx   <= r_have ? 12'(r_best_idx) : '0;
            r_out_en    <= r_have ? r_best_en : '0;
            r_out_dsq   <= r_have ? r_best_d : '0;
            r_out_root  <= r_have ? r_root : '0;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out_found;
    assign m_axis_tdata    = {3'b000, r_out_root, r_out_dsq, r_out_en, r_out_idx};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ENTRIES))
        else $error("Entry count exceeds capacity.");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt != '0))
        else $error("Scan started on an empty store.");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("Distance pipeline still busy while ready.");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("Result without match carries nonzero fields.");

endmodule
